// ===== rtl/core/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and constants of the duty ramp generator
// Default widths, item kind codes, shift unit opcodes and sequencer states.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // Default field widths
  localparam int DUTY_BITS_DEF       = 16;
  localparam int SPAN_BITS_DEF       = 16;
  localparam int SLOPE_FRAC_BITS_DEF = 6;
  localparam int TIME_BITS           = 32;

  // Smallest slope stored for a nonzero span
  localparam int SLOPE_FLOOR = 1;

  // Operand width of the shift unit at the default widths
  localparam int OPND_BITS_DEF =
    (DUTY_BITS_DEF + SLOPE_FRAC_BITS_DEF > SPAN_BITS_DEF) ?
    (DUTY_BITS_DEF + SLOPE_FRAC_BITS_DEF) : SPAN_BITS_DEF;

  // Request kinds carried on tuser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } pdr_op_t;

  typedef struct packed {
    logic    start;
    pdr_op_t op;
  } pdr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_EMIT
  } pdr_state_t;

endpackage

// ===== rtl/core/pwm_duty_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// pwm_duty_ramp_generator: linear duty ramp with a fixed-point slope
// Start requests set up a ramp, poll requests return the duty for a time.
// ----------------------------------------------------------------------------
// Input channel (s_*): tuser is the kind, 0 starts a ramp, 1 polls it. A start
// request stores start and end duty, start time, span and a slope
// |end - start| * 2^SLOPE_FRAC_BITS / span (at least 1, all ones for a zero
// span); it returns nothing. A poll returns one result on the output channel
// (m_*): the fallback duty when no ramp runs or the span has gone by, else
// start +/- slope * elapsed, clamped at the end duty.
// Timing: one request at a time, s_tready is high only while idle. The slope
// division and the slope times elapsed product run bit by bit through one
// shared shift-add unit of OPND_BITS = max(DUTY_BITS + SLOPE_FRAC_BITS,
// SPAN_BITS) bits (22 at the defaults). A start runs through the prep and run
// states (prep only for a zero span); a poll of a running ramp through prep,
// run and emit to the output register, any other poll through prep and emit.
// Reset clears the sequencer, the output valid and the ramp active flag.
// Output stall: the result waits in the output register; the block still
// takes the next request and holds it before the output only if the
// register is still full when that request's result is ready.
// ----------------------------------------------------------------------------
module pwm_duty_ramp_generator
  import pdr_pkg::*;
#(
  parameter int DUTY_BITS       = DUTY_BITS_DEF,
  parameter int SPAN_BITS       = SPAN_BITS_DEF,
  parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // request in
  input  logic s_tvalid,
  output logic s_tready,
  // now_ms, start_duty, end_duty, span_ms, fallback_duty (lowest bit up)
  input  logic [((TIME_BITS + 3*DUTY_BITS + SPAN_BITS + 7)/8)*8-1:0] s_tdata,
  // kind
  input  logic s_tuser,
  // result out
  output logic m_tvalid,
  input  logic m_tready,
  // duty_out, duty_written, ramp_running (lowest bit up)
  output logic [((DUTY_BITS + 2 + 7)/8)*8-1:0] m_tdata
);

  localparam int SLOPE_BITS = DUTY_BITS + SLOPE_FRAC_BITS;
  localparam int OPND_BITS  = (SLOPE_BITS > SPAN_BITS) ? SLOPE_BITS : SPAN_BITS;
  localparam int PROD_BITS  = 2 * OPND_BITS;
  localparam int STEP_BITS  = PROD_BITS - SLOPE_FRAC_BITS;
  localparam int START_LSB  = TIME_BITS;
  localparam int END_LSB    = TIME_BITS + DUTY_BITS;
  localparam int SPAN_LSB   = TIME_BITS + 2*DUTY_BITS;
  localparam int FB_LSB     = TIME_BITS + 2*DUTY_BITS + SPAN_BITS;

  // Sequencer
  pdr_state_t state;
  pdr_state_t state_next;

  // Held request
  logic                 item_kind;
  logic [TIME_BITS-1:0] item_now;
  logic [DUTY_BITS-1:0] item_start;
  logic [DUTY_BITS-1:0] item_end;
  logic [SPAN_BITS-1:0] item_span;
  logic [DUTY_BITS-1:0] item_fallback;

  // Ramp state; span_len stands for the end time minus the start time
  logic [DUTY_BITS-1:0]  ramp_from;
  logic [DUTY_BITS-1:0]  ramp_to;
  logic [DUTY_BITS-1:0]  ramp_diff;
  logic [TIME_BITS-1:0]  begin_time;
  logic [SPAN_BITS-1:0]  span_len;
  logic [SLOPE_BITS-1:0] slope_value;
  logic                  rising;
  logic                  active;

  // Pending result and output register
  logic [DUTY_BITS-1:0] res_duty;
  logic                 res_written;
  logic                 res_running;
  logic [DUTY_BITS-1:0] out_duty;
  logic                 out_written;
  logic                 out_running;

  // Shift unit
  pdr_cmd_t             cmd;
  logic [OPND_BITS-1:0] opnd_a;
  logic [OPND_BITS-1:0] opnd_b;
  logic                 unit_done;
  logic [OPND_BITS-1:0] unit_hi;
  logic [OPND_BITS-1:0] unit_lo;

  // Datapath around the unit
  logic                  s_accept;
  logic                  out_free;
  logic                  is_start;
  logic                  start_rising;
  logic [DUTY_BITS-1:0]  start_diff;
  logic                  span_zero;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  overrun;
  logic [PROD_BITS-1:0]  product;
  logic [STEP_BITS-1:0]  step;
  logic                  overshoot;
  logic [DUTY_BITS-1:0]  ramp_duty;
  logic [SLOPE_BITS-1:0] quotient;

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_start = (item_kind == KIND_START);

  always_comb begin
    start_rising = item_end > item_start;
    start_diff   = start_rising ? (item_end - item_start) : (item_start - item_end);
    span_zero    = (item_span == '0);
    // wrap-safe elapsed time since the ramp began
    elapsed      = item_now - begin_time;
    overrun      = elapsed > TIME_BITS'(span_len);
    product      = {unit_hi, unit_lo};
    step         = product[PROD_BITS-1:SLOPE_FRAC_BITS];
    overshoot    = step > STEP_BITS'(ramp_diff);
    ramp_duty    = rising ? (ramp_from + step[DUTY_BITS-1:0])
                          : (ramp_from - step[DUTY_BITS-1:0]);
    quotient     = unit_lo[SLOPE_BITS-1:0];
  end

  // Launch the divider for a start with a nonzero span, the multiplier for
  // a poll of a ramp that is still inside its span.
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    opnd_a    = OPND_BITS'(elapsed[SPAN_BITS-1:0]);
    opnd_b    = OPND_BITS'(slope_value);
    if (is_start) begin
      cmd.op = OP_DIV;
      opnd_a = OPND_BITS'(start_diff) << SLOPE_FRAC_BITS;
      opnd_b = OPND_BITS'(item_span);
    end
    if (state == ST_PREP) begin
      cmd.start = is_start ? !span_zero : (active && !overrun);
    end
  end

  pdr_shift_unit #(
    .OPND_BITS (OPND_BITS)
  ) u_shift (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .done   (unit_done),
    .hi     (unit_hi),
    .lo     (unit_lo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (is_start) begin
          state_next = span_zero ? ST_IDLE : ST_RUN;
        end else begin
          state_next = (!active || overrun) ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (unit_done) begin
          state_next = is_start ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_kind     <= s_tuser;
      item_now      <= s_tdata[TIME_BITS-1:0];
      item_start    <= s_tdata[START_LSB +: DUTY_BITS];
      item_end      <= s_tdata[END_LSB +: DUTY_BITS];
      item_span     <= s_tdata[SPAN_LSB +: SPAN_BITS];
      item_fallback <= s_tdata[FB_LSB +: DUTY_BITS];
    end
  end

  // Ramp state and pending result
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      if (is_start) begin
        ramp_from  <= item_start;
        ramp_to    <= item_end;
        ramp_diff  <= start_diff;
        begin_time <= item_now;
        span_len   <= item_span;
        rising     <= start_rising;
        if (span_zero) begin
          slope_value <= '1;
        end
      end else begin
        res_duty    <= item_fallback;
        res_written <= 1'b0;
        res_running <= 1'b0;
      end
    end
    if ((state == ST_RUN) && unit_done) begin
      if (is_start) begin
        slope_value <= (quotient == '0) ? SLOPE_BITS'(SLOPE_FLOOR) : quotient;
      end else if (overshoot) begin
        // clamp at the end duty
        res_duty    <= ramp_to;
        res_written <= 1'b1;
        res_running <= 1'b0;
      end else begin
        res_duty    <= ramp_duty;
        res_written <= 1'b1;
        res_running <= 1'b1;
      end
    end
  end

  // Active flag: set by a start, drop on a late poll or an overshoot
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (state == ST_PREP) begin
      if (is_start) begin
        active <= span_zero ? 1'b1 : active;
      end else if (overrun) begin
        active <= 1'b0;
      end
    end else if ((state == ST_RUN) && unit_done) begin
      if (is_start) begin
        active <= 1'b1;
      end else if (overshoot) begin
        active <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      out_duty    <= res_duty;
      out_written <= res_written;
      out_running <= res_running;
    end
  end

  always_comb begin
    m_tdata                = '0;
    m_tdata[DUTY_BITS-1:0] = out_duty;
    m_tdata[DUTY_BITS]     = out_written;
    m_tdata[DUTY_BITS+1]   = out_running;
  end

endmodule

// ===== rtl/core/pdr_shift_unit.sv =====
// ----------------------------------------------------------------------------
// pdr_shift_unit: shared shift-add / shift-subtract unit
// One adder serves a restoring divider and a shift-add multiplier, one bit
// per cycle over the OPND_BITS operand bits.
// ----------------------------------------------------------------------------
module pdr_shift_unit
  import pdr_pkg::*;
#(
  parameter int OPND_BITS = OPND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pdr_cmd_t             cmd,
  input  logic [OPND_BITS-1:0] opnd_a,   // dividend or multiplier
  input  logic [OPND_BITS-1:0] opnd_b,   // divisor or multiplicand
  output logic                 done,
  output logic [OPND_BITS-1:0] hi,       // product high half
  output logic [OPND_BITS-1:0] lo        // product low half or quotient
);

  localparam int ACC_BITS = OPND_BITS + 1;
  localparam int CNT_BITS = $clog2(OPND_BITS);

  logic [ACC_BITS-1:0]  acc;
  logic [OPND_BITS-1:0] sh;
  logic [OPND_BITS-1:0] mcand;
  pdr_op_t              op;
  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;

  logic [ACC_BITS-1:0]  rem_shift;
  logic [ACC_BITS-1:0]  add_a;
  logic [ACC_BITS-1:0]  add_b;
  logic                 sub;
  logic [ACC_BITS:0]    sum;
  logic                 no_borrow;
  logic [ACC_BITS-1:0]  acc_next;
  logic [OPND_BITS-1:0] sh_next;

  always_comb begin
    rem_shift = {acc[ACC_BITS-2:0], sh[OPND_BITS-1]};
    sub       = (op == OP_DIV);
    if (sub) begin
      add_a = rem_shift;
      add_b = ~{1'b0, mcand};
    end else begin
      add_a = acc;
      add_b = sh[0] ? {1'b0, mcand} : '0;
    end
    sum       = {1'b0, add_a} + {1'b0, add_b} + {{ACC_BITS{1'b0}}, sub};
    no_borrow = sum[ACC_BITS];
    if (sub) begin
      // keep the difference only when the divisor fits
      acc_next = no_borrow ? sum[ACC_BITS-1:0] : rem_shift;
      sh_next  = {sh[OPND_BITS-2:0], no_borrow};
    end else begin
      acc_next = {1'b0, sum[ACC_BITS-1:1]};
      sh_next  = {sum[0], sh[OPND_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
      op   <= OP_MUL;
    end else begin
      done <= busy && (cnt == CNT_BITS'(OPND_BITS - 1));
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= cmd.op;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(OPND_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc   <= '0;
      sh    <= opnd_a;
      mcand <= opnd_b;
    end else if (busy) begin
      acc <= acc_next;
      sh  <= sh_next;
    end
  end

  assign hi = acc[OPND_BITS-1:0];
  assign lo = sh;

endmodule

// ===== test/pwm_duty_ramp_generator_tb.sv =====
// ----------------------------------------------------------------------------
// pwm_duty_ramp_generator_tb: self-checking bench for the duty ramp generator
// Walks a directed table of start and poll requests, then random ramps with
// polls spread over their spans, while both stream sides idle at random. Every
// poll result is checked field by field against its typed-in value or a local ramp model.
// ----------------------------------------------------------------------------
module pwm_duty_ramp_generator_tb
  import pdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUTY_W = DUTY_BITS_DEF;
  localparam int SPAN_W = SPAN_BITS_DEF;
  localparam int FRAC_W = SLOPE_FRAC_BITS_DEF;
  localparam int SLOPE_W = DUTY_W + FRAC_W;
  localparam int S_W = ((TIME_BITS + 3*DUTY_W + SPAN_W + 7)/8)*8;
  localparam int M_W = ((DUTY_W + 2 + 7)/8)*8;
  localparam logic [SLOPE_W-1:0] SLOPE_ALL = '1;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int REPORT_MAX      = 10;
  localparam int DIRECTED_ROWS   = 25;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_ms;
    logic [DUTY_W-1:0] start_duty;
    logic [DUTY_W-1:0] end_duty;
    logic [SPAN_W-1:0] span_ms;
    logic [DUTY_W-1:0] fallback_duty;
  } ramp_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_out;
    logic              duty_written;
    logic              ramp_running;
  } ramp_res_t;

  // One directed row: the request, whether the result is typed in, and that result
  typedef struct packed {
    ramp_req_t req;
    logic      typed;
    ramp_res_t want;
  } plan_row_t;

  logic           clk;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [S_W-1:0] s_tdata;
  logic           s_tuser;
  logic           m_tvalid;
  logic           m_tready;
  logic [M_W-1:0] m_tdata;

  pwm_duty_ramp_generator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Ramp state as the block should hold it
  logic [DUTY_W-1:0]  ramp_from;
  logic [DUTY_W-1:0]  ramp_to;
  logic [31:0]        t_begin;
  logic [31:0]        t_finish;
  logic [SLOPE_W-1:0] slope;
  logic               rising;
  logic               live;

  ramp_res_t duty_due[$];     // poll results still owed by the block
  int        faults;
  int        cycles;
  int        requests_sent;
  bit        calm;            // when set, neither side idles

  // Apply one request to the ramp state; return 1 when it yields a result.
  function automatic bit advance_ramp(input ramp_req_t rq, output ramp_res_t res);
    logic [63:0] diff;
    logic [63:0] quo;
    logic [63:0] step;
    logic [31:0] elapsed;
    logic [31:0] length;
    res = '0;
    if (rq.kind == KIND_START) begin
      diff = (rq.end_duty > rq.start_duty) ? 64'(rq.end_duty) - 64'(rq.start_duty)
                                           : 64'(rq.start_duty) - 64'(rq.end_duty);
      if (rq.span_ms == '0) begin
        slope = SLOPE_ALL;
      end else begin
        quo = (diff << FRAC_W) / 64'(rq.span_ms);
        slope = quo[SLOPE_W-1:0];
        if (slope == '0) slope = SLOPE_W'(SLOPE_FLOOR);
      end
      ramp_from = rq.start_duty;
      ramp_to   = rq.end_duty;
      t_begin   = rq.now_ms;
      t_finish  = rq.now_ms + 32'(rq.span_ms);
      rising    = rq.end_duty > rq.start_duty;
      live      = 1'b1;
      return 1'b0;
    end
    res.duty_out = rq.fallback_duty;
    if (!live) return 1'b1;
    // Wrap-safe: both sides are distances from the start time
    elapsed = rq.now_ms - t_begin;
    length  = t_finish - t_begin;
    if (elapsed > length) begin
      live = 1'b0;
      return 1'b1;
    end
    // slope < 2^22 and elapsed < 2^32, so the product never leaves 64 bits
    step = (64'(slope) * 64'(elapsed)) >> FRAC_W;
    diff = rising ? 64'(ramp_to) - 64'(ramp_from) : 64'(ramp_from) - 64'(ramp_to);
    if (step > diff) begin
      res.duty_out = ramp_to;
      live = 1'b0;
    end else if (rising) begin
      res.duty_out = ramp_from + step[DUTY_W-1:0];
    end else begin
      res.duty_out = ramp_from - step[DUTY_W-1:0];
    end
    res.duty_written = 1'b1;
    res.ramp_running = live;
    return 1'b1;
  endfunction

  // Drive one request after a random gap and hold it until accepted.
  task automatic issue_request(input ramp_req_t rq, input bit typed, input ramp_res_t want);
    int        gap;
    ramp_res_t res;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= rq.kind;
    s_tdata  <= S_W'({rq.fallback_duty, rq.span_ms, rq.end_duty, rq.start_duty, rq.now_ms});
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (advance_ramp(rq, res)) duty_due.push_back(typed ? want : res);
  endtask

  // Directed part: extremes, wrap of the tick counter, zero span, equal duties,
  // the step landing exactly on the end duty and the minimum slope overshooting it.
  plan_row_t plan [DIRECTED_ROWS] = '{
    // polls after reset: no ramp yet, fallback comes back
    '{'{KIND_POLL,  32'h0000_0000, 'h0, 'h0, 'h0, 'hffff}, 1'b1, '{'hffff, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'hffff_ffff, 'h0, 'h0, 'h0, 'h0000}, 1'b1, '{'h0000, 1'b0, 1'b0}},
    // zero span, full rise: slope saturates, only elapsed 0 is inside the ramp
    '{'{KIND_START, 32'h0000_0064, 'h0, 'hffff, 'h0, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_0064, 'h0, 'h0, 'h0, 'h5555}, 1'b1, '{'h0000, 1'b1, 1'b1}},
    '{'{KIND_POLL,  32'h0000_0065, 'h0, 'h0, 'h0, 'h1234}, 1'b1, '{'h1234, 1'b0, 1'b0}},
    // rise across the wrap of the tick counter
    '{'{KIND_START, 32'hffff_fff0, 'h3e8, 'h7d0, 'h40, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'hffff_fffa, 'h0, 'h0, 'h0, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_0010, 'h0, 'h0, 'h0, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_0030, 'h0, 'h0, 'h0, 'h0}, 1'b1, '{'h07d0, 1'b1, 1'b1}},
    '{'{KIND_POLL,  32'h0000_0031, 'h0, 'h0, 'h0, 'habcd}, 1'b1, '{'habcd, 1'b0, 1'b0}},
    // long falling ramp over the widest span
    '{'{KIND_START, 32'h0000_1388, 'hea60, 'h64, 'hffff, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_88b8, 'h0, 'h0, 'h0, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0001_1387, 'h0, 'h0, 'h0, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0001_1388, 'h0, 'h0, 'h0, 'h00ff}, 1'b1, '{'h00ff, 1'b0, 1'b0}},
    // equal duties: falling with no distance, holds the level
    '{'{KIND_START, 32'h0000_0000, 'h8000, 'h8000, 'ha, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_0000, 'h0, 'h0, 'h0, 'h0}, 1'b1, '{'h8000, 1'b1, 1'b1}},
    '{'{KIND_POLL,  32'h0000_000a, 'h0, 'h0, 'h0, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_000b, 'h0, 'h0, 'h0, 'h7777}, 1'b1, '{'h7777, 1'b0, 1'b0}},
    // minimum slope overshoots a one-step ramp: clamp to the end and stop
    '{'{KIND_START, 32'h0000_0000, 'h64, 'h65, 'hffff, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h0000_00c8, 'h0, 'h0, 'h0, 'h0}, 1'b1, '{'h0065, 1'b1, 1'b0}},
    '{'{KIND_POLL,  32'h0000_00c9, 'h0, 'h0, 'h0, 'h0f0f}, 1'b1, '{'h0f0f, 1'b0, 1'b0}},
    // full fall in one tick: the step equals the distance exactly
    '{'{KIND_START, 32'h7fff_ffff, 'hffff, 'h0, 'h1, 'h0}, 1'b0, '{'h0, 1'b0, 1'b0}},
    '{'{KIND_POLL,  32'h8000_0000, 'h0, 'h0, 'h0, 'h0}, 1'b1, '{'h0000, 1'b1, 1'b1}},
    '{'{KIND_POLL,  32'h7fff_ffff, 'h0, 'h0, 'h0, 'h0}, 1'b1, '{'hffff, 1'b1, 1'b1}},
    '{'{KIND_POLL,  32'h8000_0001, 'h0, 'h0, 'h0, 'h2222}, 1'b1, '{'h2222, 1'b0, 1'b0}}
  };

  // Result side: compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    ramp_res_t got;
    ramp_res_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[DUTY_W-1:0], m_tdata[DUTY_W], m_tdata[DUTY_W+1]};
      if (duty_due.size() == 0) begin
        if (faults < REPORT_MAX)
          $display("[%0t] result with nothing owed: duty %h written %b running %b",
                   $realtime, got.duty_out, got.duty_written, got.ramp_running);
        faults++;
      end else begin
        exp_res = duty_due.pop_front();
        if (got !== exp_res) begin
          if (faults < REPORT_MAX)
            $display("[%0t] mismatch: exp duty %h written %b running %b, got %h %b %b",
                     $realtime, exp_res.duty_out, exp_res.duty_written,
                     exp_res.ramp_running, got.duty_out, got.duty_written,
                     got.ramp_running);
          faults++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pwm_duty_ramp_generator_tb: errors");
      $finish;
    end
  end

  // Receiver: stall a random number of cycles before taking each result
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  // Stimulus
  initial begin
    ramp_req_t rq;
    ramp_res_t none;
    int        polls;
    int        pick;
    logic [31:0] elapsed;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = KIND_START;
    s_tdata = '0;
    faults = 0;
    cycles = 0;
    requests_sent = 0;
    calm = 1'b0;
    none = '0;
    ramp_from = '0;
    ramp_to = '0;
    t_begin = '0;
    t_finish = '0;
    slope = '0;
    rising = 1'b0;
    live = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      issue_request(plan[i].req, plan[i].typed, plan[i].want);

    // Hold the sender until the block has handed back every owed result
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (duty_due.size() != 0) @(posedge clk);

    requests_sent = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        // Well-formed ramp: a start, then polls placed relative to its span
        rq = '0;
        rq.kind = KIND_START;
        rq.now_ms = ($urandom_range(0, 5) == 0) ? 32'hffff_ffff - $urandom_range(0, 300)
                                                 : $urandom();
        pick = $urandom_range(0, 3);
        case (pick)
          0: begin
            rq.start_duty = $urandom();
            rq.end_duty   = $urandom();
          end
          1: begin
            rq.start_duty = $urandom_range(0, 1) ? '1 : '0;
            rq.end_duty   = $urandom_range(0, 1) ? '1 : '0;
          end
          2: begin
            rq.start_duty = $urandom();
            rq.end_duty   = rq.start_duty + DUTY_W'($urandom_range(0, 8)) - DUTY_W'(4);
          end
          default: begin
            rq.start_duty = $urandom();
            rq.end_duty   = rq.start_duty;
          end
        endcase
        pick = $urandom_range(0, 3);
        case (pick)
          0: rq.span_ms = $urandom_range(0, 3);
          1: rq.span_ms = $urandom_range(1, 300);
          2: rq.span_ms = $urandom();
          default: rq.span_ms = '1;
        endcase
        issue_request(rq, 1'b0, none);

        polls = $urandom_range(1, 8);
        for (int p = 0; p < polls; p++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6)       elapsed = $urandom_range(0, rq.span_ms);
          else if (pick == 6) elapsed = 32'(rq.span_ms);
          else if (pick == 7) elapsed = 32'(rq.span_ms) + $urandom_range(0, 3);
          else if (pick == 8) elapsed = '0;
          else                elapsed = $urandom();
          issue_request('{KIND_POLL, rq.now_ms + elapsed, DUTY_W'($urandom()),
                          DUTY_W'($urandom()), SPAN_W'($urandom()),
                          DUTY_W'($urandom())}, 1'b0, none);
        end
      end else begin
        // Noise: a few requests with every field random
        polls = $urandom_range(1, 4);
        for (int p = 0; p < polls; p++)
          issue_request('{$urandom_range(0, 1) ? KIND_POLL : KIND_START, $urandom(),
                          DUTY_W'($urandom()), DUTY_W'($urandom()),
                          SPAN_W'($urandom()), DUTY_W'($urandom())}, 1'b0, none);
      end
    end

    // Drain: let the last results out, then keep the clock running so a stray result is still caught
    @(negedge clk);
    s_tvalid <= 1'b0;
    calm = 1'b0;
    while (duty_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (faults == 0) begin
      $display("pwm_duty_ramp_generator_tb: clean");
    end else begin
      $display("pwm_duty_ramp_generator_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pdr_pkg.sv
rtl/core/pdr_shift_unit.sv
rtl/core/pwm_duty_ramp_generator.sv
test/pwm_duty_ramp_generator_tb.sv
